// ===== hdl/cte_pkg.sv =====
package cte_pkg;

    // output encodings selected by the mode register
    typedef enum logic [1:0] {
        MODE_UTF8   = 2'd0,
        MODE_ASCII  = 2'd1,
        MODE_LATIN1 = 2'd2,
        MODE_LATIN2 = 2'd3
    } t_mode;

    // how an item is turned into bytes, settled at the front stage
    typedef enum logic [2:0] {
        KIND_FAIL   = 3'd0,
        KIND_DIRECT = 3'd1,
        KIND_QMARK  = 3'd2,
        KIND_LOOKUP = 3'd3,
        KIND_UTF2   = 3'd4,
        KIND_UTF3   = 3'd5,
        KIND_UTF4   = 3'd6
    } t_kind;

    localparam logic [7:0]  QMARK     = 8'h3f;
    localparam logic [20:0] CP_ASCII  = 21'h00007f;
    localparam logic [20:0] CP_UTF2   = 21'h0007ff;
    localparam logic [20:0] CP_UTF3   = 21'h00ffff;
    localparam logic [20:0] CP_MAX    = 21'h10ffff;

    localparam int LAT1_LEN = 120;
    localparam int LAT2_LEN = 116;
    localparam int LAT_LEN  = 120;
    localparam int LAT_IW   = $clog2(LAT_LEN);

    // item as it travels down the search pipeline
    typedef struct packed {
        logic [20:0] code_point;
        t_kind       kind;
        logic        lat2;
        logic [7:0]  lo;
        logic [7:0]  top;
        logic        found;
        logic [7:0]  code;
    } t_item;

    localparam logic [15:0] LAT1_KEY [LAT_LEN] = '{
        16'd160, 16'd161, 16'd162, 16'd163, 16'd164, 16'd165, 16'd166, 16'd167,
        16'd168, 16'd169, 16'd170, 16'd171, 16'd172, 16'd173, 16'd174, 16'd175,
        16'd176, 16'd177, 16'd178, 16'd179, 16'd180, 16'd181, 16'd182, 16'd183,
        16'd184, 16'd185, 16'd186, 16'd187, 16'd188, 16'd189, 16'd190, 16'd191,
        16'd192, 16'd193, 16'd194, 16'd195, 16'd196, 16'd197, 16'd198, 16'd199,
        16'd200, 16'd201, 16'd202, 16'd203, 16'd204, 16'd205, 16'd206, 16'd207,
        16'd208, 16'd209, 16'd210, 16'd211, 16'd212, 16'd213, 16'd214, 16'd215,
        16'd216, 16'd217, 16'd218, 16'd219, 16'd220, 16'd221, 16'd222, 16'd223,
        16'd224, 16'd225, 16'd226, 16'd227, 16'd228, 16'd229, 16'd230, 16'd231,
        16'd232, 16'd233, 16'd234, 16'd235, 16'd236, 16'd237, 16'd238, 16'd239,
        16'd240, 16'd241, 16'd242, 16'd243, 16'd244, 16'd245, 16'd246, 16'd247,
        16'd248, 16'd249, 16'd250, 16'd251, 16'd252, 16'd253, 16'd254, 16'd255,
        16'd338, 16'd339, 16'd372, 16'd373, 16'd374, 16'd375,
        16'd8211, 16'd8212, 16'd8216, 16'd8217, 16'd8220, 16'd8221, 16'd8222,
        16'd8224, 16'd8225, 16'd8226, 16'd8230, 16'd8240, 16'd8249, 16'd8250,
        16'd8482, 16'd8722, 16'd64257, 16'd64258
    };

    localparam logic [7:0] LAT1_CODE [LAT_LEN] = '{
        8'ha0, 8'ha1, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7,
        8'ha8, 8'ha9, 8'haa, 8'hab, 8'hac, 8'had, 8'hae, 8'haf,
        8'hb0, 8'hb1, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6, 8'hb7,
        8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'hbe, 8'hbf,
        8'hc0, 8'hc1, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7,
        8'hc8, 8'hc9, 8'hca, 8'hcb, 8'hcc, 8'hcd, 8'hce, 8'hcf,
        8'hd0, 8'hd1, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7,
        8'hd8, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde, 8'hdf,
        8'he0, 8'he1, 8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7,
        8'he8, 8'he9, 8'hea, 8'heb, 8'hec, 8'hed, 8'hee, 8'hef,
        8'hf0, 8'hf1, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7,
        8'hf8, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff,
        8'h9a, 8'h9b, 8'h81, 8'h82, 8'h85, 8'h86,
        8'h97, 8'h98, 8'h90, 8'h91, 8'h94, 8'h95, 8'h96,
        8'h9c, 8'h9d, 8'h8f, 8'h8c, 8'h8e, 8'h92, 8'h93,
        8'h8d, 8'h99, 8'h9e, 8'h9f
    };

    // padded to the common length, the tail is never searched
    localparam logic [15:0] LAT2_KEY [LAT_LEN] = '{
        16'd160, 16'd164, 16'd167, 16'd168, 16'd173, 16'd176, 16'd180, 16'd184,
        16'd193, 16'd194, 16'd196, 16'd199, 16'd201, 16'd203, 16'd205, 16'd206,
        16'd211, 16'd212, 16'd214, 16'd215, 16'd218, 16'd220, 16'd221, 16'd223,
        16'd225, 16'd226, 16'd228, 16'd231, 16'd233, 16'd235, 16'd237, 16'd238,
        16'd243, 16'd244, 16'd246, 16'd247, 16'd250, 16'd252, 16'd253,
        16'd258, 16'd259, 16'd260, 16'd261, 16'd262, 16'd263, 16'd268, 16'd269,
        16'd270, 16'd271, 16'd272, 16'd273, 16'd280, 16'd281, 16'd282, 16'd283,
        16'd313, 16'd314, 16'd317, 16'd318, 16'd321, 16'd322, 16'd323, 16'd324,
        16'd327, 16'd328, 16'd336, 16'd337, 16'd338, 16'd339, 16'd340, 16'd341,
        16'd344, 16'd345, 16'd346, 16'd347, 16'd350, 16'd351, 16'd352, 16'd353,
        16'd354, 16'd355, 16'd356, 16'd357, 16'd366, 16'd367, 16'd368, 16'd369,
        16'd377, 16'd378, 16'd379, 16'd380, 16'd381, 16'd382,
        16'd774, 16'd775, 16'd779, 16'd780, 16'd808,
        16'd8211, 16'd8212, 16'd8216, 16'd8217, 16'd8220, 16'd8221, 16'd8222,
        16'd8224, 16'd8225, 16'd8226, 16'd8230, 16'd8240, 16'd8249, 16'd8250,
        16'd8482, 16'd8722, 16'd64257, 16'd64258,
        16'hffff, 16'hffff, 16'hffff, 16'hffff
    };

    localparam logic [7:0] LAT2_CODE [LAT_LEN] = '{
        8'ha0, 8'ha4, 8'ha7, 8'ha8, 8'had, 8'hb0, 8'hb4, 8'hb8,
        8'hc1, 8'hc2, 8'hc4, 8'hc7, 8'hc9, 8'hcb, 8'hcd, 8'hce,
        8'hd3, 8'hd4, 8'hd6, 8'hd7, 8'hda, 8'hdc, 8'hdd, 8'hdf,
        8'he1, 8'he2, 8'he4, 8'he7, 8'he9, 8'heb, 8'hed, 8'hee,
        8'hf3, 8'hf4, 8'hf6, 8'hf7, 8'hfa, 8'hfc, 8'hfd,
        8'hc3, 8'he3, 8'ha1, 8'hb1, 8'hc6, 8'he6, 8'hc8, 8'he8,
        8'hcf, 8'hef, 8'hd0, 8'hf0, 8'hca, 8'hea, 8'hcc, 8'hec,
        8'hc5, 8'he5, 8'ha5, 8'hb5, 8'ha3, 8'hb3, 8'hd1, 8'hf1,
        8'hd2, 8'hf2, 8'hd5, 8'hf5, 8'h9a, 8'h9b, 8'hc0, 8'he0,
        8'hd8, 8'hf8, 8'ha6, 8'hb6, 8'haa, 8'hba, 8'ha9, 8'hb9,
        8'hde, 8'hfe, 8'hab, 8'hbb, 8'hd9, 8'hf9, 8'hdb, 8'hfb,
        8'hac, 8'hbc, 8'haf, 8'hbf, 8'hae, 8'hbe,
        8'ha2, 8'hff, 8'hbd, 8'hb7, 8'hb2,
        8'h97, 8'h98, 8'h90, 8'h91, 8'h94, 8'h95, 8'h96,
        8'h9c, 8'h9d, 8'h8f, 8'h8c, 8'h8e, 8'h92, 8'h93,
        8'h8d, 8'h99, 8'h9e, 8'h9f,
        8'h3f, 8'h3f, 8'h3f, 8'h3f
    };

endpackage

// ===== hdl/cte_front.sv =====
module cte_front import cte_pkg::*; #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mode       i_mode,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [20:0] i_code_point,
    input  logic [3:0]  i_buffer_room,
    output logic        o_valid,
    output t_item       o_item,
    input  logic        i_ready
);

    localparam int SIZE1 = (TABLE_DEPTH < LAT1_LEN) ? TABLE_DEPTH : LAT1_LEN;
    localparam int SIZE2 = (TABLE_DEPTH < LAT2_LEN) ? TABLE_DEPTH : LAT2_LEN;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // classify the code point and check the room
    always_comb begin
        n_item            = '0;
        n_item.code_point = i_code_point;
        n_item.lat2       = (i_mode == MODE_LATIN2);
        n_item.code       = QMARK;
        n_item.kind       = KIND_FAIL;
        if (i_mode == MODE_LATIN1 || i_mode == MODE_LATIN2) begin
            if (i_buffer_room < 4'd2) begin
                n_item.kind = KIND_FAIL;
            end else if (i_code_point <= CP_ASCII) begin
                n_item.kind = KIND_DIRECT;
            end else begin
                n_item.kind = KIND_LOOKUP;
                n_item.top  = (i_mode == MODE_LATIN2) ? 8'(SIZE2) : 8'(SIZE1);
            end
        end else if (i_mode == MODE_ASCII && i_code_point > CP_ASCII) begin
            n_item.kind = (i_buffer_room < 4'd2) ? KIND_FAIL : KIND_QMARK;
        end else if (i_code_point <= CP_ASCII) begin
            n_item.kind = (i_buffer_room < 4'd2) ? KIND_FAIL : KIND_DIRECT;
        end else if (i_code_point <= CP_UTF2) begin
            n_item.kind = (i_buffer_room < 4'd3) ? KIND_FAIL : KIND_UTF2;
        end else if (i_code_point <= CP_UTF3) begin
            n_item.kind = (i_buffer_room < 4'd4) ? KIND_FAIL : KIND_UTF3;
        end else if (i_code_point <= CP_MAX) begin
            n_item.kind = (i_buffer_room < 4'd5) ? KIND_FAIL : KIND_UTF4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== hdl/cte_probe.sv =====
module cte_probe import cte_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_ready
);

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic [8:0]  sum;
    logic [7:0]  mid;
    logic [15:0] key;
    logic [7:0]  code;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // one probe of the binary search, top is one past the last candidate
    always_comb begin
        n_item = i_item;
        sum    = {1'b0, i_item.lo} + {1'b0, i_item.top} - 9'd1;
        mid    = sum[8:1];
        key    = i_item.lat2 ? LAT2_KEY[mid[LAT_IW-1:0]] : LAT1_KEY[mid[LAT_IW-1:0]];
        code   = i_item.lat2 ? LAT2_CODE[mid[LAT_IW-1:0]] : LAT1_CODE[mid[LAT_IW-1:0]];
        if (!i_item.found && i_item.lo < i_item.top) begin
            if ({5'd0, key} == i_item.code_point) begin
                n_item.found = 1'b1;
                n_item.code  = code;
            end else if ({5'd0, key} < i_item.code_point) begin
                n_item.lo = mid + 8'd1;
            end else begin
                n_item.top = mid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== hdl/cte_emit.sv =====
module cte_emit import cte_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_item      i_item,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_encoded_ok,
    output logic       o_last_of_run
);

    logic       r_hv;
    t_item      r_item;
    logic [1:0] r_idx;
    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_bvalid;
    logic       r_ok;
    logic       r_last;

    logic       load_out;
    logic       last;
    logic [1:0] last_idx;
    logic [7:0] byte_sel;
    logic       ok_sel;
    logic [7:0] s0;
    logic [7:0] s1;
    logic [7:0] s2;

    assign load_out = r_hv && (!r_ov || !i_stall);
    assign last     = (r_idx == last_idx);
    assign o_ready  = !r_hv || (load_out && last);

    assign o_valid       = r_ov;
    assign o_out_byte    = r_byte;
    assign o_byte_valid  = r_bvalid;
    assign o_encoded_ok  = r_ok;
    assign o_last_of_run = r_last;

    always_comb begin
        s0       = {2'b10, r_item.code_point[5:0]};
        s1       = {2'b10, r_item.code_point[11:6]};
        s2       = {2'b10, r_item.code_point[17:12]};
        last_idx = 2'd0;
        byte_sel = 8'd0;
        ok_sel   = 1'b1;
        unique case (r_item.kind)
            KIND_FAIL: begin
                ok_sel = 1'b0;
            end
            KIND_DIRECT: begin
                byte_sel = {1'b0, r_item.code_point[6:0]};
            end
            KIND_QMARK: begin
                byte_sel = QMARK;
                ok_sel   = 1'b0;
            end
            KIND_LOOKUP: begin
                byte_sel = r_item.code;
                ok_sel   = r_item.found;
            end
            KIND_UTF2: begin
                last_idx = 2'd1;
                byte_sel = (r_idx == 2'd0) ? {3'b110, r_item.code_point[10:6]} : s0;
            end
            KIND_UTF3: begin
                last_idx = 2'd2;
                unique case (r_idx)
                    2'd0:    byte_sel = {4'b1110, r_item.code_point[15:12]};
                    2'd1:    byte_sel = s1;
                    default: byte_sel = s0;
                endcase
            end
            KIND_UTF4: begin
                last_idx = 2'd3;
                unique case (r_idx)
                    2'd0:    byte_sel = {5'b11110, r_item.code_point[20:18]};
                    2'd1:    byte_sel = s2;
                    2'd2:    byte_sel = s1;
                    default: byte_sel = s0;
                endcase
            end
            default: begin
                ok_sel = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv  <= 1'b0;
            r_ov  <= 1'b0;
            r_idx <= 2'd0;
        end else begin
            if (o_ready) begin
                r_hv <= i_valid;
            end
            if (load_out) begin
                r_ov  <= 1'b1;
                r_idx <= last ? 2'd0 : r_idx + 2'd1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
        if (load_out) begin
            r_byte   <= byte_sel;
            r_bvalid <= (r_item.kind != KIND_FAIL);
            r_ok     <= ok_sel;
            r_last   <= last;
        end
    end

endmodule

// ===== hdl/codepoint_to_charset_encoder_unit.sv =====
// channel   | direction | handshake                   | payload
// ----------+-----------+-----------------------------+---------------------------------------
// input     | in        | i_in_valid / o_in_stall     | i_code_point, i_buffer_room
// output    | out       | o_out_valid / i_out_stall   | o_out_byte, o_byte_valid,
//           |           |                             | o_encoded_ok, o_last_of_run
// config    | in        | psel, penable, pwrite       | paddr, pwdata, prdata, pready
//
// an item runs through a front stage, a chain of search probe stages and the emit stage;
// NPROBE = clog2(min(TABLE_DEPTH,120) + 1) sets the length of the chain
// the emit stage sends one result per cycle unless the output stalls, so a UTF-8 item gives
// one to four results, all else one; single-result items thus stream at one item per cycle
// synchronous reset empties every stage and sets the target mode to UTF-8
// a stall on the output backs up stage by stage; nothing is lost or repeated
module codepoint_to_charset_encoder_unit import cte_pkg::*; #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [20:0] i_code_point,
    input  logic [3:0]  i_buffer_room,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_encoded_ok,
    output logic        o_last_of_run,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SIZE_MAX = (TABLE_DEPTH < LAT1_LEN) ? TABLE_DEPTH : LAT1_LEN;
    localparam int NPROBE   = $clog2(SIZE_MAX + 1);

    localparam logic REG_TARGET_MODE = 1'b0;

    t_mode r_mode;
    logic  front_ready;
    logic  wr_en;

    // stage links: 0 is the front output, NPROBE feeds the emit stage
    t_item s_item  [NPROBE+1];
    logic  s_valid [NPROBE+1];
    logic  s_ready [NPROBE+1];

    // register port, word address in paddr[2]
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TARGET_MODE);
    assign prdata = (paddr[2] == REG_TARGET_MODE) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_UTF8;
        end else if (wr_en) begin
            r_mode <= t_mode'(pwdata[1:0]);
        end
    end

    assign o_in_stall = !front_ready;

    cte_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (r_mode),
        .i_valid       (i_in_valid),
        .o_ready       (front_ready),
        .i_code_point  (i_code_point),
        .i_buffer_room (i_buffer_room),
        .o_valid       (s_valid[0]),
        .o_item        (s_item[0]),
        .i_ready       (s_ready[0])
    );

    // one probe per stage, each narrows lo/top by half
    for (genvar g = 0; g < NPROBE; g++) begin : g_probe
        cte_probe u_probe (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .o_ready (s_ready[g]),
            .i_item  (s_item[g]),
            .o_valid (s_valid[g+1]),
            .o_item  (s_item[g+1]),
            .i_ready (s_ready[g+1])
        );
    end

    // holds one item and walks its bytes into the output register
    cte_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_valid[NPROBE]),
        .o_ready       (s_ready[NPROBE]),
        .i_item        (s_item[NPROBE]),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_encoded_ok  (o_encoded_ok),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== hdl/cte_check.sv =====
module cte_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_encoded_ok,
    input logic       o_last_of_run
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_byte_valid) && $stable(o_encoded_ok) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // a failure is a single empty result
    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_last_of_run && !o_encoded_ok
            && (o_out_byte == 8'd0))
        else $error("malformed failure result");

    // the bytes of one multi-byte item follow without a gap
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_run |=> o_out_valid && o_byte_valid
            && o_encoded_ok)
        else $error("gap or bad flags inside a multi-byte run");

endmodule

bind codepoint_to_charset_encoder_unit cte_check u_cte_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_byte    (o_out_byte),
    .o_byte_valid  (o_byte_valid),
    .o_encoded_ok  (o_encoded_ok),
    .o_last_of_run (o_last_of_run)
);

// ===== dv/codepoint_to_charset_encoder_unit_tb.sv =====
`timescale 1ns / 100ps

module codepoint_to_charset_encoder_unit_tb;
    import cte_pkg::*;

    // register map and limits
    localparam logic [2:0]  REG_TARGET_MODE = 3'd0;
    localparam int          WATCHDOG_LIMIT  = 2000;
    // more than the pipeline needs to empty at the default table depth
    localparam int          SETTLE_CYCLES   = 16;
    localparam int          RANDOM_PHASES   = 8;
    localparam int          ITEMS_PER_PHASE = 24;

    // code point boundaries of the encodings
    localparam logic [20:0] LAST_ASCII   = 21'h00007f;
    localparam logic [20:0] LAST_2BYTE   = 21'h0007ff;
    localparam logic [20:0] LAST_3BYTE   = 21'h00ffff;
    localparam logic [20:0] LAST_UNICODE = 21'h10ffff;
    localparam logic [7:0]  QUESTION     = 8'h3f;

    // one output item as seen on the result channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       encoded_ok;
        logic       last_of_run;
    } t_encoded_byte;

    localparam t_encoded_byte NO_ROOM    = '{8'h00, 1'b0, 1'b0, 1'b1};
    localparam t_encoded_byte UNMAPPED   = '{QUESTION, 1'b1, 1'b0, 1'b1};
    localparam t_encoded_byte NOT_TYPED  = '{8'h00, 1'b0, 1'b0, 1'b0};

    // latin-1 maps 160..255 onto itself, these follow it
    localparam int         LATIN1_EXTRA_KEY  [6] = '{338, 339, 372, 373, 374, 375};
    localparam logic [7:0] LATIN1_EXTRA_CODE [6] = '{8'h9a, 8'h9b, 8'h81, 8'h82, 8'h85, 8'h86};

    // latin-2 entries below the punctuation block
    localparam int LATIN2_HEAD_KEY [98] = '{
        160, 164, 167, 168, 173, 176, 180, 184,
        193, 194, 196, 199, 201, 203, 205, 206,
        211, 212, 214, 215, 218, 220, 221, 223,
        225, 226, 228, 231, 233, 235, 237, 238,
        243, 244, 246, 247, 250, 252, 253,
        258, 259, 260, 261, 262, 263, 268, 269,
        270, 271, 272, 273, 280, 281, 282, 283,
        313, 314, 317, 318, 321, 322, 323, 324,
        327, 328, 336, 337, 338, 339, 340, 341,
        344, 345, 346, 347, 350, 351, 352, 353,
        354, 355, 356, 357, 366, 367, 368, 369,
        377, 378, 379, 380, 381, 382,
        774, 775, 779, 780, 808
    };
    localparam logic [7:0] LATIN2_HEAD_CODE [98] = '{
        8'ha0, 8'ha4, 8'ha7, 8'ha8, 8'had, 8'hb0, 8'hb4, 8'hb8,
        8'hc1, 8'hc2, 8'hc4, 8'hc7, 8'hc9, 8'hcb, 8'hcd, 8'hce,
        8'hd3, 8'hd4, 8'hd6, 8'hd7, 8'hda, 8'hdc, 8'hdd, 8'hdf,
        8'he1, 8'he2, 8'he4, 8'he7, 8'he9, 8'heb, 8'hed, 8'hee,
        8'hf3, 8'hf4, 8'hf6, 8'hf7, 8'hfa, 8'hfc, 8'hfd,
        8'hc3, 8'he3, 8'ha1, 8'hb1, 8'hc6, 8'he6, 8'hc8, 8'he8,
        8'hcf, 8'hef, 8'hd0, 8'hf0, 8'hca, 8'hea, 8'hcc, 8'hec,
        8'hc5, 8'he5, 8'ha5, 8'hb5, 8'ha3, 8'hb3, 8'hd1, 8'hf1,
        8'hd2, 8'hf2, 8'hd5, 8'hf5, 8'h9a, 8'h9b, 8'hc0, 8'he0,
        8'hd8, 8'hf8, 8'ha6, 8'hb6, 8'haa, 8'hba, 8'ha9, 8'hb9,
        8'hde, 8'hfe, 8'hab, 8'hbb, 8'hd9, 8'hf9, 8'hdb, 8'hfb,
        8'hac, 8'hbc, 8'haf, 8'hbf, 8'hae, 8'hbe,
        8'ha2, 8'hff, 8'hbd, 8'hb7, 8'hb2
    };

    // punctuation and ligatures, common to both latin tables
    localparam int SHARED_TAIL_KEY [18] = '{
        8211, 8212, 8216, 8217, 8220, 8221, 8222, 8224, 8225,
        8226, 8230, 8240, 8249, 8250, 8482, 8722, 64257, 64258
    };
    localparam logic [7:0] SHARED_TAIL_CODE [18] = '{
        8'h97, 8'h98, 8'h90, 8'h91, 8'h94, 8'h95, 8'h96, 8'h9c, 8'h9d,
        8'h8f, 8'h8c, 8'h8e, 8'h92, 8'h93, 8'h8d, 8'h99, 8'h9e, 8'h9f
    };

    // one directed item: mode, payload, and the result where it is obvious
    typedef struct packed {
        t_mode         mode;
        logic [20:0]   code_point;
        logic [3:0]    room;
        logic          typed;
        t_encoded_byte want;
    } t_directed_item;

    localparam int DIRECTED_ITEMS = 25;
    localparam t_directed_item DIRECTED [DIRECTED_ITEMS] = '{
        // utf-8: edges of every length, room one short, beyond unicode
        '{MODE_UTF8,   21'h000000, 4'd2,  1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}},
        '{MODE_UTF8,   21'h00007f, 4'd15, 1'b1, '{8'h7f, 1'b1, 1'b1, 1'b1}},
        '{MODE_UTF8,   21'h000041, 4'd1,  1'b1, NO_ROOM},
        '{MODE_UTF8,   21'h000080, 4'd3,  1'b0, NOT_TYPED},
        '{MODE_UTF8,   21'h0007ff, 4'd2,  1'b1, NO_ROOM},
        '{MODE_UTF8,   21'h000800, 4'd4,  1'b0, NOT_TYPED},
        '{MODE_UTF8,   21'h00d800, 4'd4,  1'b0, NOT_TYPED},
        '{MODE_UTF8,   21'h00ffff, 4'd3,  1'b1, NO_ROOM},
        '{MODE_UTF8,   21'h010000, 4'd5,  1'b0, NOT_TYPED},
        '{MODE_UTF8,   21'h10ffff, 4'd15, 1'b0, NOT_TYPED},
        '{MODE_UTF8,   21'h110000, 4'd15, 1'b1, NO_ROOM},
        '{MODE_UTF8,   21'h1fffff, 4'd15, 1'b1, NO_ROOM},
        // seven-bit: pass-through, substitute, no room
        '{MODE_ASCII,  21'h00007f, 4'd2,  1'b1, '{8'h7f, 1'b1, 1'b1, 1'b1}},
        '{MODE_ASCII,  21'h000080, 4'd2,  1'b1, UNMAPPED},
        '{MODE_ASCII,  21'h1fffff, 4'd15, 1'b1, UNMAPPED},
        '{MODE_ASCII,  21'h000080, 4'd1,  1'b1, NO_ROOM},
        '{MODE_ASCII,  21'h000000, 4'd0,  1'b1, NO_ROOM},
        // latin-1: pass-through, first and last entry, misses
        '{MODE_LATIN1, 21'h000041, 4'd2,  1'b1, '{8'h41, 1'b1, 1'b1, 1'b1}},
        '{MODE_LATIN1, 21'h0000a0, 4'd2,  1'b0, NOT_TYPED},
        '{MODE_LATIN1, 21'h00fb02, 4'd3,  1'b0, NOT_TYPED},
        '{MODE_LATIN1, 21'h000100, 4'd2,  1'b1, UNMAPPED},
        '{MODE_LATIN1, 21'h1fffff, 4'd15, 1'b1, UNMAPPED},
        // latin-2: no room on a hit, last entry, a hole in the table
        '{MODE_LATIN2, 21'h0000a0, 4'd1,  1'b1, NO_ROOM},
        '{MODE_LATIN2, 21'h00fb02, 4'd2,  1'b0, NOT_TYPED},
        '{MODE_LATIN2, 21'h0000a1, 4'd2,  1'b1, UNMAPPED}
    };

    // clock, reset and block inputs, all known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [20:0] i_code_point  = '0;
    logic [3:0]  i_buffer_room = '0;
    logic        i_out_stall   = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_encoded_ok;
    logic        o_last_of_run;
    logic [31:0] prdata;
    logic        pready;

    // testbench copy of the mode register and the results still owed
    t_mode           charset_mode = MODE_UTF8;
    t_encoded_byte   expected_bytes [$];
    int              error_count  = 0;
    int              quiet_cycles = 0;
    int              send_idle_pct = 0;
    int              stall_pct     = 0;

    always #6 i_clk = ~i_clk;

    codepoint_to_charset_encoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_code_point  (i_code_point),
        .i_buffer_room (i_buffer_room),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_encoded_ok  (o_encoded_ok),
        .o_last_of_run (o_last_of_run),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // table lookup for the latin targets; the tables are sorted with unique
    // keys, so a plain scan finds exactly what the binary search finds
    function automatic logic latin_code(input t_mode mode, input logic [20:0] cp,
                                        output logic [7:0] code);
        int i;
        code = QUESTION;
        if (mode == MODE_LATIN1) begin
            if (cp >= 21'd160 && cp <= 21'd255) begin
                code = cp[7:0];
                return 1'b1;
            end
            for (i = 0; i < 6; i++) begin
                if (cp == 21'(LATIN1_EXTRA_KEY[i])) begin
                    code = LATIN1_EXTRA_CODE[i];
                    return 1'b1;
                end
            end
        end else begin
            for (i = 0; i < 98; i++) begin
                if (cp == 21'(LATIN2_HEAD_KEY[i])) begin
                    code = LATIN2_HEAD_CODE[i];
                    return 1'b1;
                end
            end
        end
        for (i = 0; i < 18; i++) begin
            if (cp == 21'(SHARED_TAIL_KEY[i])) begin
                code = SHARED_TAIL_CODE[i];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // works out the bytes one code point turns into and queues them
    function automatic void predict_encoding(input logic [20:0] cp, input logic [3:0] room);
        logic [7:0] seq [4];
        int         n;
        logic       ok;
        int         k;
        ok = 1'b1;
        n  = 0;
        if (cp <= LAST_ASCII) begin
            n = 1;
            seq[0] = cp[7:0];
        end else if (charset_mode == MODE_ASCII) begin
            n = 1;
            seq[0] = QUESTION;
            ok = 1'b0;
        end else if (charset_mode != MODE_UTF8) begin
            n = 1;
            ok = latin_code(charset_mode, cp, seq[0]);
        end else if (cp <= LAST_2BYTE) begin
            n = 2;
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
        end else if (cp <= LAST_3BYTE) begin
            // surrogates land here too, plain three-byte form
            n = 3;
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
        end else if (cp <= LAST_UNICODE) begin
            n = 4;
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
        end
        // beyond unicode in utf-8, or no room for the bytes and terminator
        if (n == 0 || int'(room) < n + 1) begin
            expected_bytes.push_back(NO_ROOM);
        end else begin
            for (k = 0; k < n; k++)
                expected_bytes.push_back('{seq[k], 1'b1, ok, k == n - 1});
        end
    endfunction

    // any key of either latin table
    function automatic logic [20:0] pick_table_key();
        case ($urandom_range(0, 2))
            0: return 21'($urandom_range(160, 255));
            1: return 21'(LATIN2_HEAD_KEY[$urandom_range(0, 97)]);
            default: begin
                if ($urandom_range(0, 3) == 0)
                    return 21'(LATIN1_EXTRA_KEY[$urandom_range(0, 5)]);
                return 21'(SHARED_TAIL_KEY[$urandom_range(0, 17)]);
            end
        endcase
    endfunction

    // spread over every encoding length, the range beyond unicode and the tables
    function automatic logic [20:0] pick_code_point();
        case ($urandom_range(0, 9))
            0, 1:    return 21'($urandom_range(0, 127));
            2:       return 21'($urandom_range(128, 32'h7ff));
            3:       return 21'($urandom_range(32'h800, 32'hffff));
            4:       return 21'($urandom_range(32'h10000, 32'h10ffff));
            5:       return 21'($urandom_range(32'h110000, 32'h1fffff));
            6, 7:    return pick_table_key();
            // neighbors of table keys, mostly holes
            8:       return ($urandom_range(0, 1) != 0) ? pick_table_key() + 21'd1
                                                        : pick_table_key() - 21'd1;
            default: return 21'($urandom_range(128, 32'hffff));
        endcase
    endfunction

    // mostly enough room, a quarter of the time near the limits
    function automatic logic [3:0] pick_room();
        if ($urandom_range(0, 3) == 0)
            return 4'($urandom_range(0, 5));
        return 4'($urandom_range(0, 15));
    endfunction

    // presents one item and returns at the edge that takes it; valid stays
    // high so a following item goes out back to back
    task automatic send_item(input logic [20:0] cp, input logic [3:0] room,
                             input logic typed, input t_encoded_byte want);
        if (typed)
            expected_bytes.push_back(want);
        else
            predict_encoding(cp, room);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_code_point  <= cp;
        i_buffer_room <= room;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    // one register access, setup then access phase
    task automatic reg_access(input logic write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= REG_TARGET_MODE;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // reads the mode register back and compares with the local copy
    task automatic check_mode_reg();
        logic [31:0] rdata;
        reg_access(1'b0, 32'h0, rdata);
        if (rdata !== {30'h0, charset_mode}) begin
            error_count++;
            $display("%0t: target_mode read expected %h actual %h",
                     $time, {30'h0, charset_mode}, rdata);
        end
    endtask

    // mode changes only with the block empty: drain, let the pipe settle, write
    task automatic set_target_mode(input t_mode mode);
        logic [31:0] rdata;
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        reg_access(1'b1, {30'h0, mode}, rdata);
        charset_mode = mode;
        check_mode_reg();
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // result checker, compares each taken item with the oldest expectation
    always @(posedge i_clk) begin
        t_encoded_byte got;
        t_encoded_byte want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_out_byte, o_byte_valid, o_encoded_ok, o_last_of_run};
            if (expected_bytes.size() == 0) begin
                error_count++;
                $display("%0t: unexpected item byte %h valid %b ok %b last %b",
                         $time, got.out_byte, got.byte_valid, got.encoded_ok,
                         got.last_of_run);
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display({"%0t: expected byte %h valid %b ok %b last %b,",
                              " actual byte %h valid %b ok %b last %b"},
                             $time, want.out_byte, want.byte_valid, want.encoded_ok,
                             want.last_of_run, got.out_byte, got.byte_valid,
                             got.encoded_ok, got.last_of_run);
                end
            end
        end
    end

    // watchdog on cycles where no channel moves anything
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("codepoint_to_charset_encoder_unit_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int row;
        int phase;
        int k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value of the mode register
        check_mode_reg();

        // directed items, full speed on both sides
        for (row = 0; row < DIRECTED_ITEMS; row++) begin
            if (DIRECTED[row].mode != charset_mode)
                set_target_mode(DIRECTED[row].mode);
            send_item(DIRECTED[row].code_point, DIRECTED[row].room,
                      DIRECTED[row].typed, DIRECTED[row].want);
        end

        // random phases: every mode once per pair of idling patterns
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_target_mode(t_mode'(phase % 4));
            case (phase / 2)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                send_item(pick_code_point(), pick_room(), 1'b0, NOT_TYPED);
        end

        // drain, then watch for stray items
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_bytes.size() == 0)
            $display("codepoint_to_charset_encoder_unit_tb OK");
        else
            $display("codepoint_to_charset_encoder_unit_tb NOT OK");
        $finish;
    end

endmodule
